FILE: hw/rtl/routed_frame_parser_macros.svh
// Assertion helpers shared by the parser RTL.
`ifndef ROUTED_FRAME_PARSER_MACROS_SVH
`define ROUTED_FRAME_PARSER_MACROS_SVH

// Check that is held off while reset is asserted
`define RFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also covers the reset cycles
`define RFP_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/rfp_pkg.sv
package rfp_pkg;

    // Parse phase, numbered like the region tag it produces
    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_TRANSPORT = 3'd1,
        PH_PLEN      = 3'd2,
        PH_PATH      = 3'd3,
        PH_PAYLOAD   = 3'd4,
        PH_DISCARD   = 3'd5
    } t_phase;

    // Frame status codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_TRUNCATED   = 3'd1;
    localparam logic [2:0] ERR_HASH_RSVD   = 3'd2;
    localparam logic [2:0] ERR_PATH_LONG   = 3'd3;
    localparam logic [2:0] ERR_PAYLOAD_LONG = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROUTE_MASK  = 2'd0;
    localparam logic [1:0] CFG_MAX_PATH    = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

    // Configuration reset values
    localparam logic [3:0] RST_ROUTE_MASK  = 4'd9;
    localparam logic [7:0] RST_MAX_PATH    = 8'd64;
    localparam logic [7:0] RST_MAX_PAYLOAD = 8'd184;

    // Transport codes occupy four bytes
    localparam logic [1:0] TRANSPORT_LAST_OFF = 2'd3;
    // Hash size code (path length byte bits 7:6) that is reserved
    localparam logic [1:0] HASH_SIZE_RSVD = 2'd3;

    typedef struct packed {
        logic [3:0] transport_route_mask;
        logic [7:0] max_path_bytes;
        logic [7:0] max_payload_bytes;
    } t_cfg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  echo_byte;
        logic [2:0]  region;
        logic [7:0]  region_offset;
        logic        frame_done;
        logic [2:0]  error_code;
        logic [1:0]  route_kind;
        logic [3:0]  content_type;
        logic [1:0]  format_version;
        logic [15:0] first_code;
        logic [15:0] second_code;
        logic [5:0]  hops;
        logic [2:0]  hash_bytes;
    } t_out_item;

    // Offset increment that sticks at 255
    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        sat_inc = (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

endpackage

FILE: hw/rtl/routed_frame_parser.sv
// Routed frame parser: takes a frame one byte per request, flagged on its
// last byte, and returns one result per byte: the byte itself, its region
// (header, transport codes, path length, path, payload, discarded), its
// offset in that region, the header and path-length fields held so far and,
// on the last byte, the frame status. A new byte is accepted every cycle
// unless the input register is held by a stalled output; each byte passes
// through an input register, one pass of phase-update logic and a result
// register. Configuration is to be written through its own port only while
// no frame byte is in flight; the block itself does not enforce this.
`include "routed_frame_parser_macros.svh"

module routed_frame_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rfp_pkg::t_in_item  i_in_data,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rfp_pkg::t_out_item o_out_data,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    import rfp_pkg::*;

    t_cfg      w_cfg;
    t_in_item  r_in;
    logic      r_in_valid, n_in_valid;
    t_out_item r_out;
    logic      r_out_valid, n_out_valid;
    t_out_item w_result;
    logic      w_out_free;
    logic      w_step;
    logic      w_in_free;
    logic      w_in_take;

    rfp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    rfp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_step   (w_step),
        .i_item   (r_in),
        .o_result (w_result)
    );

    // Flow control: each register moves when the one after it frees up
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign w_in_free  = !r_in_valid || w_step;
    assign w_in_take  = i_in_valid && w_in_free;
    assign o_in_stall = !w_in_free;

    always_comb begin
        n_in_valid  = w_in_take ? 1'b1 : (w_step ? 1'b0 : r_in_valid);
        n_out_valid = w_step ? 1'b1 : (w_out_free ? 1'b0 : r_out_valid);
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in_data;
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `RFP_ASSERT(a_status_on_done, i_clk, i_rst_n, (r_out_valid && !r_out.frame_done) |-> (r_out.error_code == ERR_NONE), "status reported before the last byte")
    `RFP_ASSERT(a_step_lands, i_clk, i_rst_n, w_step |=> r_out_valid, "parsed byte did not reach the result register")
    `RFP_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> (!r_in_valid && !r_out_valid), "pipeline not empty after reset")

endmodule

FILE: hw/rtl/rfp_cfg.sv
module rfp_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output rfp_pkg::t_cfg     o_cfg
);
    import rfp_pkg::*;

    logic [3:0] r_route_mask;
    logic [7:0] r_max_path;
    logic [7:0] r_max_payload;
    logic       w_wr;

    // Writes are taken in any cycle
    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid && o_cfg_ready;

    // Register file; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route_mask  <= RST_ROUTE_MASK;
            r_max_path    <= RST_MAX_PATH;
            r_max_payload <= RST_MAX_PAYLOAD;
        end else if (w_wr) begin
            unique case (i_cfg_index)
                CFG_ROUTE_MASK:  r_route_mask  <= i_cfg_data[3:0];
                CFG_MAX_PATH:    r_max_path    <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.transport_route_mask = r_route_mask;
    assign o_cfg.max_path_bytes       = r_max_path;
    assign o_cfg.max_payload_bytes    = r_max_payload;

endmodule

FILE: hw/rtl/rfp_parse.sv
`include "routed_frame_parser_macros.svh"

module rfp_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rfp_pkg::t_cfg      i_cfg,
    input  logic               i_step,
    input  rfp_pkg::t_in_item  i_item,
    output rfp_pkg::t_out_item o_result
);
    import rfp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_offset, n_offset;
    logic [7:0]  r_path_need, n_path_need;
    logic [7:0]  r_header, n_header;
    logic [15:0] r_code_a, n_code_a;
    logic [15:0] r_code_b, n_code_b;
    logic [5:0]  r_hops, n_hops;
    logic [2:0]  r_hash, n_hash;
    logic [2:0]  r_error, n_error;

    logic [7:0]  w_b;
    logic        w_last;
    logic [2:0]  w_region;
    logic [7:0]  w_off;
    logic [2:0]  w_err;
    logic [7:0]  w_need;

    assign w_b    = i_item.byte_value;
    assign w_last = i_item.last_byte;

    // Phase update and held fields for one byte
    always_comb begin
        n_phase     = r_phase;
        n_offset    = r_offset;
        n_path_need = r_path_need;
        n_header    = r_header;
        n_code_a    = r_code_a;
        n_code_b    = r_code_b;
        n_hops      = r_hops;
        n_hash      = r_hash;
        n_error     = r_error;
        w_region    = PH_DISCARD;
        w_off       = r_offset;
        w_err       = ERR_NONE;
        w_need      = 8'({2'b00, w_b[5:0]} * {6'b0, w_b[7:6]} + {2'b00, w_b[5:0]});

        unique case (r_phase)
            PH_HEADER: begin
                w_region    = PH_HEADER;
                w_off       = 8'd0;
                n_header    = w_b;
                n_code_a    = 16'd0;
                n_code_b    = 16'd0;
                n_hops      = 6'd0;
                n_hash      = 3'd1;
                n_path_need = 8'd0;
                n_error     = ERR_NONE;
                n_offset    = 8'd0;
                n_phase     = i_cfg.transport_route_mask[w_b[1:0]] ? PH_TRANSPORT : PH_PLEN;
                if (w_last) begin
                    w_err = ERR_TRUNCATED;
                end
            end
            PH_TRANSPORT: begin
                w_region = PH_TRANSPORT;
                w_off    = {6'd0, r_offset[1:0]};
                unique case (r_offset[1:0])
                    2'd0: n_code_a[7:0]  = w_b;
                    2'd1: n_code_a[15:8] = w_b;
                    2'd2: n_code_b[7:0]  = w_b;
                    default: n_code_b[15:8] = w_b;
                endcase
                if (r_offset[1:0] == TRANSPORT_LAST_OFF) begin
                    n_phase  = PH_PLEN;
                    n_offset = 8'd0;
                end else begin
                    n_offset = w_off + 8'd1;
                end
                if (w_last) begin
                    w_err = ERR_TRUNCATED;
                end
            end
            PH_PLEN: begin
                w_region = PH_PLEN;
                w_off    = 8'd0;
                n_hops   = w_b[5:0];
                n_hash   = {1'b0, w_b[7:6]} + 3'd1;
                n_offset = 8'd0;
                if (w_b[7:6] == HASH_SIZE_RSVD) begin
                    w_err = ERR_HASH_RSVD;
                end else begin
                    // hops * (size code + 1)
                    n_path_need = w_need;
                    if (w_need > i_cfg.max_path_bytes) begin
                        w_err = ERR_PATH_LONG;
                    end else if (w_need == 8'd0) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_PATH;
                        if (w_last) begin
                            w_err = ERR_TRUNCATED;
                        end
                    end
                end
            end
            PH_PATH: begin
                w_region = PH_PATH;
                if ({1'b0, r_offset} + 9'd1 >= {1'b0, r_path_need}) begin
                    n_phase  = PH_PAYLOAD;
                    n_offset = 8'd0;
                end else begin
                    n_offset = sat_inc(r_offset);
                    if (w_last) begin
                        w_err = ERR_TRUNCATED;
                    end
                end
            end
            PH_PAYLOAD: begin
                w_region = PH_PAYLOAD;
                if (r_offset >= i_cfg.max_payload_bytes) begin
                    w_err = ERR_PAYLOAD_LONG;
                end
                n_offset = sat_inc(r_offset);
            end
            default: begin
                n_offset = sat_inc(r_offset);
            end
        endcase

        // First error wins and the rest of the frame is discarded
        if (w_err != ERR_NONE && n_error == ERR_NONE) begin
            n_error  = w_err;
            n_phase  = PH_DISCARD;
            n_offset = 8'd0;
        end

        // Result carries the fields as updated by this byte
        o_result.echo_byte      = w_b;
        o_result.region         = w_region;
        o_result.region_offset  = w_off;
        o_result.frame_done     = w_last;
        o_result.error_code     = w_last ? n_error : ERR_NONE;
        o_result.route_kind     = n_header[1:0];
        o_result.content_type   = n_header[5:2];
        o_result.format_version = n_header[7:6];
        o_result.first_code     = n_code_a;
        o_result.second_code    = n_code_b;
        o_result.hops           = n_hops;
        o_result.hash_bytes     = n_hash;

        // Next byte opens a new frame
        if (w_last) begin
            n_phase  = PH_HEADER;
            n_offset = 8'd0;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_offset    <= 8'd0;
            r_path_need <= 8'd0;
            r_header    <= 8'd0;
            r_code_a    <= 16'd0;
            r_code_b    <= 16'd0;
            r_hops      <= 6'd0;
            r_hash      <= 3'd1;
            r_error     <= ERR_NONE;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_offset    <= n_offset;
            r_path_need <= n_path_need;
            r_header    <= n_header;
            r_code_a    <= n_code_a;
            r_code_b    <= n_code_b;
            r_hops      <= n_hops;
            r_hash      <= n_hash;
            r_error     <= n_error;
        end
    end

    `RFP_ASSERT(a_discard_has_err, i_clk, i_rst_n, (r_phase == PH_DISCARD) |-> (r_error != ERR_NONE), "discard phase without a held error")
    `RFP_ASSERT(a_err_only_discard, i_clk, i_rst_n, (r_error != ERR_NONE) |-> (r_phase == PH_DISCARD || r_phase == PH_HEADER), "held error outside discard phase")
    `RFP_ASSERT(a_path_bound, i_clk, i_rst_n, (r_phase == PH_PATH) |-> (r_path_need != 8'd0 && r_offset < r_path_need), "path offset beyond path length")

endmodule
